FILE: rtl/core/cmp_pkg.sv
// Shared types, codes and constants for the CoAP message parser.
`timescale 1ns / 1ps

package cmp_pkg;

    localparam int TOKEN_MAX_DEFAULT = 8;

    // Result kinds
    localparam logic [2:0] KIND_NONE        = 3'd0;
    localparam logic [2:0] KIND_HEADER_DONE = 3'd1;
    localparam logic [2:0] KIND_TOKEN_BYTE  = 3'd2;
    localparam logic [2:0] KIND_OPTION_HEAD = 3'd3;
    localparam logic [2:0] KIND_OPTION_BYTE = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD     = 3'd5;
    localparam logic [2:0] KIND_ERROR       = 3'd6;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SHORT    = 3'd1;
    localparam logic [2:0] ERR_VERSION  = 3'd2;
    localparam logic [2:0] ERR_TOKEN    = 3'd3;
    localparam logic [2:0] ERR_DELTA    = 3'd4;
    localparam logic [2:0] ERR_LENGTH   = 3'd5;
    localparam logic [2:0] ERR_OVERFLOW = 3'd6;

    // Option encoding
    localparam logic [3:0]  NIBBLE_EXT1    = 4'd13;
    localparam logic [3:0]  NIBBLE_EXT2    = 4'd14;
    localparam logic [3:0]  NIBBLE_RSVD    = 4'd15;
    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
    localparam logic [16:0] EXT1_BASE      = 17'd13;
    localparam logic [16:0] EXT2_BASE      = 17'd269;

    localparam logic [1:0] EXPECTED_VERSION_RESET = 2'd1;

    typedef enum logic [7:0] {
        PH_HEADER    = 8'b0000_0001,
        PH_TOKEN     = 8'b0000_0010,
        PH_OPT_HEAD  = 8'b0000_0100,
        PH_DELTA_EXT = 8'b0000_1000,
        PH_LEN_EXT   = 8'b0001_0000,
        PH_VALUE     = 8'b0010_0000,
        PH_PAYLOAD   = 8'b0100_0000,
        PH_DISCARD   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  token_len;
        logic [7:0]  msg_code;
        logic [15:0] message_id;
        logic [15:0] option_number;
        logic [16:0] option_length;
        logic [7:0]  data_value;
        logic [2:0]  error_code;
        logic        message_end;
        logic        message_ok;
    } out_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  byte_count;
        logic [7:0]  header_first;
        logic [7:0]  code;
        logic [15:0] msgid;
        logic [3:0]  token_left;
        logic [15:0] number_accum;
        logic [3:0]  delta_nibble;
        logic [3:0]  length_nibble;
        logic [16:0] ext_value;
        logic [16:0] value_left;
        logic [2:0]  error_hold;
    } parse_state_t;

endpackage

FILE: rtl/core/cmp_decode.sv
// Per-byte decode: next parser state and the result for one datagram byte.
`timescale 1ns / 1ps

module cmp_decode #(
    parameter int TOKEN_MAX = cmp_pkg::TOKEN_MAX_DEFAULT
) (
    input  logic [1:0]            expected_version,
    input  cmp_pkg::in_item_t     item,
    input  cmp_pkg::parse_state_t state,
    output cmp_pkg::parse_state_t state_next,
    output cmp_pkg::out_item_t    result
);
    import cmp_pkg::*;

    localparam logic [3:0] TokenLimit = 4'(TOKEN_MAX);

    logic [7:0]  b;
    logic        last;
    logic [1:0]  hdr_ver;
    logic [3:0]  hdr_tkl;
    logic [3:0]  token_dec;
    logic [1:0]  count_dec;
    logic [16:0] delta_shift;
    logic [15:0] len_shift;
    logic [16:0] value_dec;
    logic [16:0] nibble_sum;
    logic [17:0] delta_sum;
    logic [16:0] delta_base;
    logic [16:0] len_base;
    logic [2:0]  err;
    logic        was_discard;
    logic        do_begin;
    logic        do_head;
    logic [16:0] head_len;
    parse_state_t ns;
    out_item_t    r;

    assign b           = item.data_byte;
    assign last        = item.last_byte;
    assign hdr_ver     = state.header_first[7:6];
    assign hdr_tkl     = state.header_first[3:0];
    assign token_dec   = state.token_left - 4'd1;
    assign count_dec   = state.byte_count - 2'd1;
    assign delta_shift = {state.ext_value[8:0], b};
    assign len_shift   = {state.ext_value[7:0], b};
    assign value_dec   = state.value_left - 17'd1;
    assign nibble_sum  = {1'b0, state.number_accum} + {13'd0, b[7:4]};
    assign delta_base  = (state.delta_nibble == NIBBLE_EXT1) ? EXT1_BASE : EXT2_BASE;
    assign len_base    = (state.length_nibble == NIBBLE_EXT1) ? EXT1_BASE : EXT2_BASE;
    assign delta_sum   = {2'b00, state.number_accum} + {1'b0, delta_shift}
                       + {1'b0, delta_base};

    always_comb
    begin
        ns          = state;
        r           = '0;
        err         = ERR_NONE;
        was_discard = 1'b0;
        do_begin    = 1'b0;
        do_head     = 1'b0;
        head_len    = '0;

        case (state.phase)
            PH_HEADER:
            begin
                case (state.byte_count)
                    2'd0:    ns.header_first = b;
                    2'd1:    ns.code = b;
                    2'd2:    ns.msgid = {b, 8'h00};
                    default: ns.msgid = {state.msgid[15:8], b};
                endcase
                if (state.byte_count != 2'd3)
                begin
                    if (last)
                        err = ERR_SHORT;
                    else
                        ns.byte_count = state.byte_count + 2'd1;
                end
                else
                begin
                    ns.byte_count = 2'd0;
                    if (hdr_ver != expected_version)
                        err = ERR_VERSION;
                    else if (hdr_tkl > TokenLimit)
                        err = ERR_TOKEN;
                    else if (last && hdr_tkl != 4'd0)
                        err = ERR_TOKEN;
                    else
                    begin
                        r.kind         = KIND_HEADER_DONE;
                        r.version      = hdr_ver;
                        r.msg_type     = state.header_first[5:4];
                        r.token_len    = hdr_tkl;
                        r.msg_code     = state.code;
                        r.message_id   = {state.msgid[15:8], b};
                        ns.token_left  = hdr_tkl;
                        ns.phase       = (hdr_tkl != 4'd0) ? PH_TOKEN : PH_OPT_HEAD;
                    end
                end
            end
            PH_TOKEN:
            begin
                ns.token_left = token_dec;
                if (last && token_dec != 4'd0)
                    err = ERR_TOKEN;
                else
                begin
                    r.kind       = KIND_TOKEN_BYTE;
                    r.data_value = b;
                    if (token_dec == 4'd0)
                        ns.phase = PH_OPT_HEAD;
                end
            end
            PH_OPT_HEAD:
            begin
                if (b == PAYLOAD_MARKER)
                begin
                    if (last)
                        err = ERR_SHORT;
                    else
                        ns.phase = PH_PAYLOAD;
                end
                else if (b[7:4] == NIBBLE_RSVD)
                    err = ERR_DELTA;
                else if (b[3:0] == NIBBLE_RSVD)
                    err = ERR_LENGTH;
                else
                begin
                    ns.delta_nibble  = b[7:4];
                    ns.length_nibble = b[3:0];
                    if (b[7:4] inside {[NIBBLE_EXT1:NIBBLE_RSVD]})
                    begin
                        ns.ext_value  = '0;
                        ns.byte_count = (b[7:4] == NIBBLE_EXT1) ? 2'd1 : 2'd2;
                        ns.phase      = PH_DELTA_EXT;
                        if (last)
                            err = ERR_DELTA;
                    end
                    else if (nibble_sum[16])
                        err = ERR_OVERFLOW;
                    else
                    begin
                        ns.number_accum = nibble_sum[15:0];
                        do_begin        = 1'b1;
                    end
                end
            end
            PH_DELTA_EXT:
            begin
                ns.ext_value  = delta_shift;
                ns.byte_count = count_dec;
                if (count_dec == 2'd0)
                begin
                    if (delta_sum[17:16] != 2'b00)
                        err = ERR_OVERFLOW;
                    else
                    begin
                        ns.number_accum = delta_sum[15:0];
                        do_begin        = 1'b1;
                    end
                end
                else if (last)
                    err = ERR_DELTA;
            end
            PH_LEN_EXT:
            begin
                ns.ext_value  = {1'b0, len_shift};
                ns.byte_count = count_dec;
                if (count_dec == 2'd0)
                begin
                    head_len = {1'b0, len_shift} + len_base;
                    do_head  = 1'b1;
                end
                else if (last)
                    err = ERR_LENGTH;
            end
            PH_VALUE:
            begin
                r.kind          = KIND_OPTION_BYTE;
                r.option_number = state.number_accum;
                r.option_length = state.ext_value;
                r.data_value    = b;
                ns.value_left   = value_dec;
                if (value_dec == 17'd0)
                    ns.phase = PH_OPT_HEAD;
                else if (last)
                    err = ERR_LENGTH;
            end
            PH_PAYLOAD:
            begin
                r.kind       = KIND_PAYLOAD;
                r.data_value = b;
            end
            default:
                was_discard = 1'b1;
        endcase

        // Delta settled: decode the length nibble
        if (do_begin)
        begin
            if (ns.length_nibble inside {[NIBBLE_EXT1:NIBBLE_RSVD]})
            begin
                ns.ext_value  = '0;
                ns.byte_count = (ns.length_nibble == NIBBLE_EXT1) ? 2'd1 : 2'd2;
                ns.phase      = PH_LEN_EXT;
                if (last)
                    err = ERR_LENGTH;
            end
            else
            begin
                head_len = {13'd0, ns.length_nibble};
                do_head  = 1'b1;
            end
        end

        // Length known: report the option head
        if (do_head)
        begin
            r.kind          = KIND_OPTION_HEAD;
            r.option_number = ns.number_accum;
            r.option_length = head_len;
            ns.ext_value    = head_len;
            ns.value_left   = head_len;
            ns.phase        = (head_len != 17'd0) ? PH_VALUE : PH_OPT_HEAD;
            if (last && head_len != 17'd0)
                err = ERR_LENGTH;
        end

        if (err != ERR_NONE)
        begin
            r             = '0;
            r.kind        = KIND_ERROR;
            r.error_code  = err;
            ns.phase      = PH_DISCARD;
            ns.error_hold = err;
        end

        // End of datagram: report status and rearm for the next header
        if (last)
        begin
            r.message_end = 1'b1;
            if (was_discard)
                r.error_code = state.error_hold;
            r.message_ok     = (err == ERR_NONE) && !was_discard;
            ns.phase         = PH_HEADER;
            ns.byte_count    = '0;
            ns.token_left    = '0;
            ns.number_accum  = '0;
            ns.delta_nibble  = '0;
            ns.length_nibble = '0;
            ns.ext_value     = '0;
            ns.value_left    = '0;
            ns.error_hold    = ERR_NONE;
        end
    end

    assign state_next = ns;
    assign result     = r;

endmodule

FILE: rtl/core/coap_message_parser.sv
// Top level of the streaming CoAP message parser.
//
// Bytes of a datagram enter on the in channel (valid/ready), one per
// transaction, with last_byte marking the final byte. Every input byte
// yields exactly one result on the out channel (valid/ready): header
// done, token byte, option head, option value byte, payload byte, error,
// or none for bytes that carry no element of their own.
// The result of a byte accepted at a clock edge is valid right after
// that edge, held in the output register.
// Throughput is one byte per cycle: decode is a single pass of logic
// from the parser state and the incoming byte into the result register,
// and in_ready stays high while the output register is empty or being
// taken in the same cycle.
// When the receiver stalls, the result stays in the output register and
// in_ready falls until it is taken; no byte is dropped.
// The cfg channel writes expected_version; it is always ready and should
// be written only while the parser is idle.
// Reset places the parser at the start of a header, clears any pending
// result and sets expected_version to 1.
`timescale 1ns / 1ps

module coap_message_parser #(
    parameter int TOKEN_MAX = cmp_pkg::TOKEN_MAX_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  cmp_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cmp_pkg::out_item_t out_data
);
    import cmp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    out_item_t    result_next;
    out_item_t    out_reg;
    logic         out_valid_reg;
    logic [1:0]   expected_version_reg;
    logic         in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    cmp_decode #(
        .TOKEN_MAX(TOKEN_MAX)
    ) u_decode (
        .expected_version(expected_version_reg),
        .item            (in_data),
        .state           (state_reg),
        .state_next      (state_next),
        .result          (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_version_reg <= EXPECTED_VERSION_RESET;
        else if (cfg_valid)
            expected_version_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase: PH_HEADER, default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load on every accepted byte, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_reg <= result_next;
    end

    a_ok_needs_clean_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.message_ok |->
            out_data.message_end && out_data.error_code == ERR_NONE)
        else $error("message_ok without a clean datagram end");

    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_ERROR |-> out_data.error_code != ERR_NONE)
        else $error("error result without an error code");

    a_header_version: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_HEADER_DONE |->
            out_data.version == expected_version_reg)
        else $error("header reported with a mismatched version");

    a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.last_byte |=>
            state_reg.phase == PH_HEADER && state_reg.number_accum == 16'd0
            && state_reg.byte_count == 2'd0)
        else $error("parser not rearmed after the last byte");

endmodule

FILE: sim/coap_message_checker.sv
// Result predictor and scoreboard for the CoAP message parser testbench.
`timescale 1ns / 1ps

module coap_message_checker #(
    parameter int TOKEN_MAX = cmp_pkg::TOKEN_MAX_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  cmp_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  cmp_pkg::out_item_t out_data,
    output int                 mismatches,
    output int                 results_due
);
    import cmp_pkg::*;

    logic [1:0]  version_sel;
    phase_t      phase;
    logic [2:0]  step_count;
    logic [7:0]  first_byte;
    logic [7:0]  code_byte;
    logic [15:0] msg_id;
    logic [3:0]  tokens_left;
    logic [15:0] opt_number;
    logic [3:0]  delta_nib;
    logic [3:0]  len_nib;
    logic [16:0] ext_acc;
    logic [16:0] value_left;
    logic [2:0]  held_error;
    out_item_t   predicted_q[$];
    int          result_num = 0;
    int          fail_tally = 0;
    int          due = 0;

    assign mismatches  = fail_tally;
    assign results_due = due;

    task automatic log_mismatch(input string text);
        $display("[%0t] mismatch: %s", $time, text);
        fail_tally++;
    endtask

    task automatic check_field(input string name, input logic [16:0] got,
                               input logic [16:0] want);
        if (got !== want)
            log_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                   result_num, name, got, want));
    endtask

    task automatic clear_message();
        phase       = PH_HEADER;
        step_count  = '0;
        tokens_left = '0;
        opt_number  = '0;
        delta_nib   = '0;
        len_nib     = '0;
        ext_acc     = '0;
        value_left  = '0;
        held_error  = ERR_NONE;
    endtask

    // Option length known: report the head and go on to its value, if any.
    task automatic close_option_head(input logic last, inout out_item_t r,
                                     output logic [2:0] err);
        r.kind          = KIND_OPTION_HEAD;
        r.option_number = opt_number;
        r.option_length = ext_acc;
        value_left      = ext_acc;
        phase           = (value_left != 0) ? PH_VALUE : PH_OPT_HEAD;
        err             = (last && value_left != 0) ? ERR_LENGTH : ERR_NONE;
    endtask

    task automatic open_length(input logic last, inout out_item_t r,
                               output logic [2:0] err);
        if (len_nib >= NIBBLE_EXT1)
        begin
            ext_acc    = '0;
            step_count = (len_nib == NIBBLE_EXT1) ? 3'd1 : 3'd2;
            phase      = PH_LEN_EXT;
            err        = last ? ERR_LENGTH : ERR_NONE;
        end
        else
        begin
            ext_acc = {13'd0, len_nib};
            close_option_head(last, r, err);
        end
    endtask

    task automatic add_delta(input int delta, input logic last, inout out_item_t r,
                             output logic [2:0] err);
        int sum;
        sum = int'(opt_number) + delta;
        if (sum > 65535)
            err = ERR_OVERFLOW;
        else
        begin
            opt_number = sum[15:0];
            open_length(last, r, err);
        end
    endtask

    // Advance the parser by one byte and work out the result it owes.
    task automatic decode_byte(input logic [7:0] b, input logic last, output out_item_t r);
        logic [2:0] err;
        logic       discarding;
        r          = '0;
        err        = ERR_NONE;
        discarding = 1'b0;
        case (phase)
            PH_HEADER:
            begin
                case (step_count)
                    3'd0:    first_byte = b;
                    3'd1:    code_byte = b;
                    3'd2:    msg_id = {b, 8'h00};
                    default: msg_id[7:0] = b;
                endcase
                if (step_count < 3'd3)
                begin
                    if (last)
                        err = ERR_SHORT;
                    else
                        step_count = step_count + 3'd1;
                end
                else
                begin
                    step_count = '0;
                    if (first_byte[7:6] != version_sel)
                        err = ERR_VERSION;
                    else if (int'(first_byte[3:0]) > TOKEN_MAX)
                        err = ERR_TOKEN;
                    else if (last && first_byte[3:0] != 4'd0)
                        err = ERR_TOKEN;
                    else
                    begin
                        r.kind         = KIND_HEADER_DONE;
                        r.version      = first_byte[7:6];
                        r.msg_type     = first_byte[5:4];
                        r.token_len    = first_byte[3:0];
                        r.msg_code     = code_byte;
                        r.message_id   = msg_id;
                        tokens_left    = first_byte[3:0];
                        phase          = (tokens_left != 0) ? PH_TOKEN : PH_OPT_HEAD;
                    end
                end
            end
            PH_TOKEN:
            begin
                tokens_left = tokens_left - 4'd1;
                if (last && tokens_left != 0)
                    err = ERR_TOKEN;
                else
                begin
                    r.kind       = KIND_TOKEN_BYTE;
                    r.data_value = b;
                    if (tokens_left == 0)
                        phase = PH_OPT_HEAD;
                end
            end
            PH_OPT_HEAD:
            begin
                if (b == PAYLOAD_MARKER)
                begin
                    if (last)
                        err = ERR_SHORT;
                    else
                        phase = PH_PAYLOAD;
                end
                else if (b[7:4] == NIBBLE_RSVD)
                    err = ERR_DELTA;
                else if (b[3:0] == NIBBLE_RSVD)
                    err = ERR_LENGTH;
                else
                begin
                    delta_nib = b[7:4];
                    len_nib   = b[3:0];
                    if (delta_nib >= NIBBLE_EXT1)
                    begin
                        ext_acc    = '0;
                        step_count = (delta_nib == NIBBLE_EXT1) ? 3'd1 : 3'd2;
                        phase      = PH_DELTA_EXT;
                        if (last)
                            err = ERR_DELTA;
                    end
                    else
                        add_delta(int'(delta_nib), last, r, err);
                end
            end
            PH_DELTA_EXT:
            begin
                ext_acc    = {ext_acc[8:0], b};
                step_count = step_count - 3'd1;
                if (step_count == 0)
                    add_delta(int'(ext_acc) + ((delta_nib == NIBBLE_EXT1) ?
                              int'(EXT1_BASE) : int'(EXT2_BASE)), last, r, err);
                else if (last)
                    err = ERR_DELTA;
            end
            PH_LEN_EXT:
            begin
                ext_acc    = {1'b0, ext_acc[7:0], b};
                step_count = step_count - 3'd1;
                if (step_count == 0)
                begin
                    ext_acc = ext_acc + ((len_nib == NIBBLE_EXT1) ? EXT1_BASE : EXT2_BASE);
                    close_option_head(last, r, err);
                end
                else if (last)
                    err = ERR_LENGTH;
            end
            PH_VALUE:
            begin
                r.kind          = KIND_OPTION_BYTE;
                r.option_number = opt_number;
                r.option_length = ext_acc;
                r.data_value    = b;
                value_left      = value_left - 17'd1;
                if (value_left == 0)
                    phase = PH_OPT_HEAD;
                else if (last)
                    err = ERR_LENGTH;
            end
            PH_PAYLOAD:
            begin
                r.kind       = KIND_PAYLOAD;
                r.data_value = b;
            end
            default:
                discarding = 1'b1;
        endcase

        if (err != ERR_NONE)
        begin
            r            = '0;
            r.kind       = KIND_ERROR;
            r.error_code = err;
            phase        = PH_DISCARD;
            held_error   = err;
        end

        if (last)
        begin
            r.message_end = 1'b1;
            if (discarding)
                r.error_code = held_error;
            r.message_ok = (err == ERR_NONE) && !discarding;
            clear_message();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            version_sel = EXPECTED_VERSION_RESET;
            first_byte  = '0;
            code_byte   = '0;
            msg_id      = '0;
            clear_message();
            predicted_q.delete();
            due = 0;
        end
        else
        begin
            // take the result first: a byte accepted at this edge cannot be answered yet
            if (out_valid && out_ready)
            begin
                if (predicted_q.size() == 0)
                    log_mismatch($sformatf("result %0d arrived with none expected",
                                           result_num));
                else
                begin
                    want = predicted_q.pop_front();
                    check_field("kind", out_data.kind, want.kind);
                    check_field("version", out_data.version, want.version);
                    check_field("msg_type", out_data.msg_type, want.msg_type);
                    check_field("token_len", out_data.token_len, want.token_len);
                    check_field("msg_code", out_data.msg_code, want.msg_code);
                    check_field("message_id", out_data.message_id, want.message_id);
                    check_field("option_number", out_data.option_number,
                                want.option_number);
                    check_field("option_length", out_data.option_length,
                                want.option_length);
                    check_field("data_value", out_data.data_value, want.data_value);
                    check_field("error_code", out_data.error_code, want.error_code);
                    check_field("message_end", out_data.message_end, want.message_end);
                    check_field("message_ok", out_data.message_ok, want.message_ok);
                end
                result_num++;
            end
            if (in_valid && in_ready)
            begin
                decode_byte(in_data.data_byte, in_data.last_byte, want);
                predicted_q = {predicted_q, want};
            end
            if (cfg_valid && cfg_ready)
                version_sel = cfg_data;
            due = predicted_q.size();
        end
    end

endmodule

FILE: sim/coap_message_parser_test.sv
// Testbench top for the CoAP message parser: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module coap_message_parser_test;
    import cmp_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam logic [1:0] VERSION_PLAN [4] = '{2'd3, 2'd0, 2'd2, 2'd1};
    localparam int         BYTES_PER_SETTING = 170;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data = 2'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b1;
    out_item_t  out_data;
    int         mismatches;
    int         results_due;
    logic       calm = 1'b0;
    logic [1:0] version_now = EXPECTED_VERSION_RESET;
    int         bytes_sent = 0;
    int         stall_left = 0;

    coap_message_parser #(
        .TOKEN_MAX(TOKEN_MAX_DEFAULT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    coap_message_checker #(
        .TOKEN_MAX(TOKEN_MAX_DEFAULT)
    ) result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .mismatches (mismatches),
        .results_due(results_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: stall in short bursts, never once the run has gone calm.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    // Entered and left at a falling edge; valid stays up between transactions except for random idle gaps before calm.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_message(input byte_q_t msg);
        foreach (msg[i])
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    // Hold off the sender until every result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic set_version(input logic [1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid   <= 1'b0;
        version_now = v;
    endtask

    task automatic append_byte(inout byte_q_t msg, input logic [7:0] b);
        msg = {msg, b};
    endtask

    // Mostly well-formed datagrams with random content; some cut, corrupted or noise.
    task automatic build_message(output byte_q_t msg);
        int         tkl;
        int         dnib;
        int         dext;
        int         lnib;
        int         len;
        int         sel;
        logic [1:0] ver;
        msg = {};
        ver = ($urandom_range(0, 11) == 0) ? 2'($urandom) : version_now;
        tkl = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 15)
                                           : $urandom_range(0, TOKEN_MAX_DEFAULT);
        append_byte(msg, {ver, 2'($urandom), 4'(tkl)});
        repeat (3) append_byte(msg, 8'($urandom));
        repeat (tkl) append_byte(msg, 8'($urandom));
        repeat ($urandom_range(0, 4))
        begin
            sel = $urandom_range(0, 5);
            if (sel == 0)
            begin
                dnib = 13;
                dext = $urandom_range(0, 255);
            end
            else if (sel == 1)
            begin
                dnib = 14;
                dext = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 300);
            end
            else
                dnib = $urandom_range(0, 12);

            sel = $urandom_range(0, 59);
            if (sel == 0)
            begin
                lnib = 14;
                len  = 269 + $urandom_range(0, 3);
            end
            else if (sel < 8)
            begin
                lnib = 13;
                len  = 13 + $urandom_range(0, 20);
            end
            else
            begin
                len  = $urandom_range(0, 12);
                lnib = len;
            end

            append_byte(msg, {4'(dnib), 4'(lnib)});
            if (dnib == 14)
                append_byte(msg, 8'(dext >> 8));
            if (dnib >= 13)
                append_byte(msg, 8'(dext));
            if (lnib == 14)
                append_byte(msg, 8'((len - 269) >> 8));
            if (lnib == 14)
                append_byte(msg, 8'(len - 269));
            else if (lnib == 13)
                append_byte(msg, 8'(len - 13));
            repeat (len) append_byte(msg, 8'($urandom));
        end
        if ($urandom_range(0, 1) == 1)
        begin
            append_byte(msg, PAYLOAD_MARKER);
            repeat ($urandom_range(1, 8)) append_byte(msg, 8'($urandom));
        end

        case ($urandom_range(0, 9))
            7:
                repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
            8:
                msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
            9:
            begin
                msg = {};
                repeat ($urandom_range(1, 10)) append_byte(msg, 8'($urandom));
            end
            default:
                ;
        endcase
    endtask

    initial
    begin
        byte_q_t msg;
        int      target;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // short header: first byte, then third byte
        msg = {8'h40};
        send_message(msg);
        msg = {8'h40, 8'h01, 8'h12};
        send_message(msg);
        // wrong version, then a discarded byte
        msg = {8'h00, 8'h01, 8'h00, 8'h01, 8'hAA};
        send_message(msg);
        // token longer than allowed; token cut by the header end; token cut after one byte
        msg = {8'h49, 8'h01, 8'h00, 8'h02};
        send_message(msg);
        msg = {8'h41, 8'h01, 8'h00, 8'h03};
        send_message(msg);
        msg = {8'h42, 8'h45, 8'hFF, 8'hFF, 8'h11};
        send_message(msg);
        // clean datagram: widest token, extended delta, options and a payload
        msg = {8'h78, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
               8'h7F, 8'hFE, 8'hD1, 8'hFF, 8'hAB, 8'hC0, 8'h32, 8'h00, 8'hFF,
               8'hFF, 8'h00, 8'hFF};
        send_message(msg);
        // reserved delta nibble; reserved length nibble
        msg = {8'h40, 8'h00, 8'h00, 8'h00, 8'hF0, 8'h33};
        send_message(msg);
        msg = {8'h40, 8'h00, 8'h00, 8'h00, 8'h0F};
        send_message(msg);
        // datagram ends inside a delta extension, then inside a length extension
        msg = {8'h40, 8'h00, 8'h00, 8'h00, 8'hE0, 8'h01};
        send_message(msg);
        msg = {8'h40, 8'h00, 8'h00, 8'h00, 8'h0E, 8'h00};
        send_message(msg);
        // option number reaches 65535, then one more step overflows
        msg = {8'h40, 8'h00, 8'h00, 8'h00, 8'hE0, 8'hFE, 8'hF2, 8'h10};
        send_message(msg);
        // payload marker as the last byte
        msg = {8'h40, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_message(msg);
        // longest option length, value cut after one byte
        msg = {8'h40, 8'h00, 8'h00, 8'h00, 8'h0E, 8'hFF, 8'hFF, 8'h5A};
        send_message(msg);
        // bare header
        msg = {8'h40, 8'h00, 8'h00, 8'h00};
        send_message(msg);

        for (int p = 0; p < $size(VERSION_PLAN); p++)
        begin
            set_version(VERSION_PLAN[p]);
            if (p == $size(VERSION_PLAN) - 1)
                calm <= 1'b1;
            target = bytes_sent + BYTES_PER_SETTING;
            while (bytes_sent < target)
            begin
                build_message(msg);
                send_message(msg);
            end
        end

        drain();
        if (mismatches == 0)
            $display("coap_message_parser regression: pass");
        else
            $display("coap_message_parser regression: fail");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("coap_message_parser regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/cmp_pkg.sv
rtl/core/cmp_decode.sv
rtl/core/coap_message_parser.sv
sim/coap_message_checker.sv
sim/coap_message_parser_test.sv
